// ----- rtl/quadrature_encoder_with_click_hold_assert.svh -----
// ----------------------------------------------------------------------------
// quadrature encoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_WITH_CLICK_HOLD_ASSERT_SVH
`define QUADRATURE_ENCODER_WITH_CLICK_HOLD_ASSERT_SVH

// same-cycle implication, disabled in reset
`define QENC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define QENC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qenc_pkg.sv -----
// ----------------------------------------------------------------------------
// qenc_pkg
// shared types, constants and the quadrature step table
// ----------------------------------------------------------------------------
`default_nettype none

package qenc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 8;

  localparam logic [CfgIdxW-1:0] REG_HOLD_TIME     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CLICK_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BUTTON_EN     = 2'd2;

  localparam logic [CfgDataW-1:0] HOLD_TIME_RST     = 16'd500;
  localparam logic [CfgDataW-1:0] CLICK_TIMEOUT_RST = 16'd300;
  localparam logic                BUTTON_EN_RST     = 1'b1;

  localparam logic [CountW-1:0] CLICK_MAX = 8'd255;

  // step enable and qualifiers handed to the button logic
  typedef struct packed {
    logic step;
    logic primed;
    logic enabled;
  } btn_ctl_t;

  // index is {previous ab, current ab}
  function automatic logic signed [1:0] quad_step(input logic [3:0] key);
    logic signed [1:0] d;
    case (key)
      4'h1, 4'h7, 4'h8, 4'he: d = 2'sb01;
      4'h2, 4'h4, 4'hb, 4'hd: d = 2'sb11;
      default:                d = 2'sb00;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/qenc_quad.sv -----
// ----------------------------------------------------------------------------
// qenc_quad
// quadrature phase decoder with first-sample priming
// ----------------------------------------------------------------------------
`default_nettype none

module qenc_quad
  import qenc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_i,
  input  wire logic [1:0]        ab_i,
  output logic                   primed_o,
  output logic                   rot_valid_o,
  output logic signed [1:0]      rot_delta_o
);

  logic [1:0]        last_ab_r, last_ab_nxt;
  logic              primed_r, primed_nxt;
  logic signed [1:0] d;

  always_comb begin
    d           = quad_step({last_ab_r, ab_i});
    last_ab_nxt = step_i ? ab_i : last_ab_r;
    primed_nxt  = primed_r | step_i;
    primed_o    = primed_r;
    // nothing decoded on the priming sample
    rot_valid_o = primed_r && (d != 2'sb00);
    rot_delta_o = primed_r ? d : 2'sb00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ab_r <= 2'b00;
      primed_r  <= 1'b0;
    end else begin
      last_ab_r <= last_ab_nxt;
      primed_r  <= primed_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qenc_button.sv -----
// ----------------------------------------------------------------------------
// qenc_button
// click counting and hold detection for the push button
// ----------------------------------------------------------------------------
`default_nettype none

module qenc_button
  import qenc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire btn_ctl_t            ctl_i,
  input  wire logic                pressed_i,
  input  wire logic [TimeW-1:0]    now_i,
  input  wire logic [CfgDataW-1:0] hold_time_i,
  input  wire logic [CfgDataW-1:0] click_timeout_i,
  output logic                     press_valid_o,
  output logic [CountW-1:0]        press_count_o
);

  logic              was_down_r, was_down_nxt;
  logic              hold_fired_r, hold_fired_nxt;
  logic [TimeW-1:0]  press_start_r, press_start_nxt;
  logic [TimeW-1:0]  last_click_r, last_click_nxt;
  logic [CountW-1:0] count_r, count_nxt;

  logic              run, rise, fall, click;
  logic [TimeW-1:0]  d_press, d_click, d_press_eff, d_click_eff;
  logic [TimeW-1:0]  hold_w, timeout_w;
  logic              hf_a;
  logic [CountW-1:0] cnt_base, cnt_a;

  always_comb begin
    run       = ctl_i.step && ctl_i.primed && ctl_i.enabled;
    hold_w    = {{(TimeW-CfgDataW){1'b0}}, hold_time_i};
    timeout_w = {{(TimeW-CfgDataW){1'b0}}, click_timeout_i};
    d_press   = now_i - press_start_r;
    d_click   = now_i - last_click_r;
    rise      = pressed_i && !was_down_r;
    fall      = !pressed_i && was_down_r;
    click     = fall && !hold_fired_r && (d_press < hold_w);

    // edge handling
    hf_a     = rise ? 1'b0 : hold_fired_r;
    cnt_base = (d_click > timeout_w) ? '0 : count_r;
    if (click) begin
      cnt_a = (cnt_base == CLICK_MAX) ? CLICK_MAX : cnt_base + CountW'(1);
    end else begin
      cnt_a = count_r;
    end
    // timestamps just replaced by now give a zero gap
    d_press_eff = rise ? '0 : d_press;
    d_click_eff = click ? '0 : d_click;

    was_down_nxt    = rise ? 1'b1 : (fall ? 1'b0 : was_down_r);
    press_start_nxt = rise ? now_i : press_start_r;
    last_click_nxt  = click ? now_i : last_click_r;
    hold_fired_nxt  = hf_a;
    count_nxt       = cnt_a;
    press_valid_o   = 1'b0;
    press_count_o   = '0;

    // hold wins over a finished click series
    if (pressed_i && !hf_a && (d_press_eff >= hold_w)) begin
      hold_fired_nxt = 1'b1;
      press_valid_o  = 1'b1;
      count_nxt      = '0;
    end else if (!pressed_i && (cnt_a != '0) && (d_click_eff > timeout_w)) begin
      press_valid_o = 1'b1;
      press_count_o = cnt_a;
      count_nxt     = '0;
    end

    if (!run) begin
      was_down_nxt    = was_down_r;
      press_start_nxt = press_start_r;
      last_click_nxt  = last_click_r;
      hold_fired_nxt  = hold_fired_r;
      count_nxt       = count_r;
      press_valid_o   = 1'b0;
      press_count_o   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_down_r    <= 1'b0;
      hold_fired_r  <= 1'b0;
      press_start_r <= '0;
      last_click_r  <= '0;
      count_r       <= '0;
    end else begin
      was_down_r    <= was_down_nxt;
      hold_fired_r  <= hold_fired_nxt;
      press_start_r <= press_start_nxt;
      last_click_r  <= last_click_nxt;
      count_r       <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/quadrature_encoder_with_click_hold.sv -----
// ----------------------------------------------------------------------------
// quadrature_encoder_with_click_hold
// quadrature decoder with click / hold push button, one result per sample
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   in       | in_valid / in_ready    | enc_ab, button_pressed, now_ms
//   out      | out_valid / out_ready  | rotate_valid/delta, press_valid/count
//   cfg      | cfg_we                 | cfg_index, cfg_wdata (no wait)
//
// one transaction per cycle sustained while out_ready stays high; each sample
// passes through the input register and then the result register
// state is updated when the sample moves from the input register into the
// result register, so consecutive samples see each other's effect
// rst_n is synchronous; it clears both valid flags, the state and the
// configuration registers
// a stalled output holds its result; the input register still takes a sample
// while the output waits, then input ready drops until the result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_with_click_hold
  import qenc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // sample input
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_enc_ab,
  input  wire logic                in_button_pressed,
  input  wire logic [TimeW-1:0]    in_now_ms,
  // result output
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_rotate_valid,
  output logic signed [1:0]        out_rotate_delta,
  output logic                     out_press_valid,
  output logic [CountW-1:0]        out_press_count,
  // configuration writes
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  // configuration registers
  logic [CfgDataW-1:0] hold_time_r;
  logic [CfgDataW-1:0] click_timeout_r;
  logic                button_en_r;

  // input register
  logic             in_vld_r;
  logic [1:0]       ab_r;
  logic             pressed_r;
  logic [TimeW-1:0] now_r;

  // result register
  logic              out_vld_r;
  logic              rot_valid_r;
  logic signed [1:0] rot_delta_r;
  logic              prs_valid_r;
  logic [CountW-1:0] prs_count_r;

  // stage control
  logic     advance;
  logic     in_take;
  logic     primed;
  logic     rot_valid_c;
  logic signed [1:0] rot_delta_c;
  logic     prs_valid_c;
  logic [CountW-1:0] prs_count_c;
  btn_ctl_t btn_ctl;

  // the sample moves on when the result slot is empty or being emptied
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  assign btn_ctl = '{step: advance, primed: primed, enabled: button_en_r};

  // configuration, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r     <= HOLD_TIME_RST;
      click_timeout_r <= CLICK_TIMEOUT_RST;
      button_en_r     <= BUTTON_EN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_TIME:     hold_time_r     <= cfg_wdata;
        REG_CLICK_TIMEOUT: click_timeout_r <= cfg_wdata;
        REG_BUTTON_EN:     button_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ab_r      <= in_enc_ab;
      pressed_r <= in_button_pressed;
      now_r     <= in_now_ms;
    end
  end

  qenc_quad u_quad (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (advance),
    .ab_i        (ab_r),
    .primed_o    (primed),
    .rot_valid_o (rot_valid_c),
    .rot_delta_o (rot_delta_c)
  );

  qenc_button u_button (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl_i           (btn_ctl),
    .pressed_i       (pressed_r),
    .now_i           (now_r),
    .hold_time_i     (hold_time_r),
    .click_timeout_i (click_timeout_r),
    .press_valid_o   (prs_valid_c),
    .press_count_o   (prs_count_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rot_valid_r <= rot_valid_c;
      rot_delta_r <= rot_delta_c;
      prs_valid_r <= prs_valid_c;
      prs_count_r <= prs_count_c;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_rotate_valid = rot_valid_r;
  assign out_rotate_delta = rot_delta_r;
  assign out_press_valid  = prs_valid_r;
  assign out_press_count  = prs_count_r;

endmodule

`default_nettype wire

// ----- rtl/qenc_checker.sv -----
// ----------------------------------------------------------------------------
// qenc_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadrature_encoder_with_click_hold_assert.svh"

module qenc_checker
  import qenc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_rotate_valid,
  input wire logic signed [1:0] out_rotate_delta,
  input wire logic              out_press_valid,
  input wire logic [CountW-1:0] out_press_count
);

  `QENC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rotate_delta) && $stable(out_press_count), "stalled result changed")

  `QENC_ASSERT_IMP(a_rot_zero, out_valid && !out_rotate_valid, out_rotate_delta == 2'sb00, "delta without a step")

  `QENC_ASSERT_IMP(a_rot_unit, out_valid && out_rotate_valid, out_rotate_delta == 2'sb01 || out_rotate_delta == 2'sb11, "step not plus or minus one")

  `QENC_ASSERT_IMP(a_press_zero, out_valid && !out_press_valid, out_press_count == '0, "count without a press event")

endmodule

bind quadrature_encoder_with_click_hold qenc_checker u_qenc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_rotate_valid (out_rotate_valid),
  .out_rotate_delta (out_rotate_delta),
  .out_press_valid  (out_press_valid),
  .out_press_count  (out_press_count)
);

`default_nettype wire

// ----- tb/quadrature_encoder_with_click_hold_test.sv -----
// ----------------------------------------------------------------------------
// quadrature_encoder_with_click_hold_test
// self-checking bench for the encoder / push-button decoder: pin samples go in
// over a valid/ready channel, each one is predicted on acceptance and the
// matching result transaction is compared field by field as it leaves
// ----------------------------------------------------------------------------
import qenc_pkg::*;

typedef struct packed {
  logic              rotate_valid;
  logic [1:0]        rotate_delta;
  logic              press_valid;
  logic [CountW-1:0] press_count;
} encoder_event_t;

class encoder_scoreboard;
  logic [CfgDataW-1:0] hold_ms;
  logic [CfgDataW-1:0] timeout_ms;
  logic                button_on;
  logic [1:0]          prev_ab;
  logic                primed;
  logic                down;
  logic                hold_done;
  logic [TimeW-1:0]    press_t0;
  logic [TimeW-1:0]    click_t;
  logic [CountW-1:0]   clicks;
  encoder_event_t      pending_events[$];
  int unsigned         mismatches;
  int unsigned         results_seen;

  function new();
    hold_ms      = HOLD_TIME_RST;
    timeout_ms   = CLICK_TIMEOUT_RST;
    button_on    = BUTTON_EN_RST;
    prev_ab      = '0;
    primed       = 1'b0;
    down         = 1'b0;
    hold_done    = 1'b0;
    press_t0     = '0;
    click_t      = '0;
    clicks       = '0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      REG_HOLD_TIME:     hold_ms    = data;
      REG_CLICK_TIMEOUT: timeout_ms = data;
      REG_BUTTON_EN:     button_on  = data[0];
      default: ;
    endcase
  endfunction

  // work out the event that one accepted sample must produce
  function void note_sample(input logic [1:0] ab, input logic btn, input logic [TimeW-1:0] now);
    encoder_event_t   ev;
    logic [1:0]       pos_old;
    logic [1:0]       pos_new;
    logic [1:0]       moved;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] gap;
    ev = '0;
    if (!primed) begin
      prev_ab = ab;
      primed  = 1'b1;
      pending_events.push_back(ev);
      return;
    end
    // position along the gray cycle 00, 01, 11, 10
    pos_old = {prev_ab[1], ^prev_ab};
    pos_new = {ab[1], ^ab};
    moved   = pos_new - pos_old;
    if (moved == 2'd1) begin
      ev.rotate_valid = 1'b1;
      ev.rotate_delta = 2'b01;
    end else if (moved == 2'd3) begin
      ev.rotate_valid = 1'b1;
      ev.rotate_delta = 2'b11;
    end
    prev_ab = ab;
    if (button_on) begin
      if (btn && !down) begin
        down      = 1'b1;
        press_t0  = now;
        hold_done = 1'b0;
      end else if (!btn && down) begin
        down = 1'b0;
        held = now - press_t0;
        if (!hold_done && held < {16'd0, hold_ms}) begin
          gap = now - click_t;
          if (gap > {16'd0, timeout_ms})
            clicks = '0;
          if (clicks != CLICK_MAX)
            clicks = clicks + CountW'(1);
          click_t = now;
        end
      end
      held = now - press_t0;
      gap  = now - click_t;
      if (btn && !hold_done && held >= {16'd0, hold_ms}) begin
        hold_done      = 1'b1;
        ev.press_valid = 1'b1;
        clicks         = '0;
      end else if (!btn && clicks != 0 && gap > {16'd0, timeout_ms}) begin
        ev.press_valid = 1'b1;
        ev.press_count = clicks;
        clicks         = '0;
      end
    end
    pending_events.push_back(ev);
  endfunction

  task report(input string what);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch: %s", what);
  endtask

  task check_result(input encoder_event_t got);
    encoder_event_t want;
    results_seen++;
    if (pending_events.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding", results_seen));
      return;
    end
    want = pending_events.pop_front();
    if (got.rotate_valid !== want.rotate_valid)
      report($sformatf("result %0d rotate_valid %b, want %b",
                       results_seen, got.rotate_valid, want.rotate_valid));
    if (got.rotate_delta !== want.rotate_delta)
      report($sformatf("result %0d rotate_delta %b, want %b",
                       results_seen, got.rotate_delta, want.rotate_delta));
    if (got.press_valid !== want.press_valid)
      report($sformatf("result %0d press_valid %b, want %b",
                       results_seen, got.press_valid, want.press_valid));
    if (got.press_count !== want.press_count)
      report($sformatf("result %0d press_count %0d, want %0d",
                       results_seen, got.press_count, want.press_count));
  endtask

  function int unsigned outstanding();
    return pending_events.size();
  endfunction
endclass

module quadrature_encoder_with_click_hold_test;

  // index past the end of the register list, writes there must be ignored
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned STALL_LIMIT   = 2000;
  // spare cycles idled at the end once the pipeline has drained
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 34;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_enc_ab;
  logic                in_button_pressed;
  logic [TimeW-1:0]    in_now_ms;
  logic                out_valid;
  logic                out_ready;
  logic                out_rotate_valid;
  logic signed [1:0]   out_rotate_delta;
  logic                out_press_valid;
  logic [CountW-1:0]   out_press_count;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  encoder_scoreboard sb;

  // stimulus state: running timestamp, last phases sent, register mirror
  logic [TimeW-1:0] clock_ms;
  logic [1:0]       cur_ab;
  int unsigned      hold_cfg;
  int unsigned      timeout_cfg;
  int unsigned      sent;
  // when set neither side idles
  bit               steady = 1'b0;

  quadrature_encoder_with_click_hold dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_enc_ab         (in_enc_ab),
    .in_button_pressed (in_button_pressed),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rotate_valid  (out_rotate_valid),
    .out_rotate_delta  (out_rotate_delta),
    .out_press_valid   (out_press_valid),
    .out_press_count   (out_press_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  // result side back-pressure, one decision per cycle
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // every result transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_rotate_valid, out_rotate_delta, out_press_valid, out_press_count});
  end

  // hang detector: counts cycles in which neither channel moves a transaction
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one sample, with a random gap in front, and hold it until taken
  task automatic send_item(input logic [1:0] ab, input logic btn, input logic [TimeW-1:0] now);
    int unsigned gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(99) < IDLE_PCT)
        gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_enc_ab         <= ab;
    in_button_pressed <= btn;
    in_now_ms         <= now;
    do
      @(posedge clk);
    while (!in_ready);
    sb.note_sample(ab, btn, now);
    sent++;
  endtask

  // stop offering and wait for every outstanding result to come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (sb.outstanding() != 0);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // back-to-back writes of all registers, plus a stray one past the list
  task automatic set_regs(input int unsigned hold, input int unsigned tmo,
                          input logic [CfgDataW-1:0] en_word);
    cfg_put(REG_HOLD_TIME, CfgDataW'(hold));
    cfg_put(REG_CLICK_TIMEOUT, CfgDataW'(tmo));
    cfg_put(REG_BUTTON_EN, en_word);
    cfg_put(REG_SPARE, CfgDataW'($urandom));
    cfg_we      <= 1'b0;
    hold_cfg    = hold & 16'hFFFF;
    timeout_cfg = tmo & 16'hFFFF;
  endtask

  // mostly legal gray steps, some dwell, a few illegal double changes
  function automatic logic [1:0] next_ab();
    logic [1:0]  pos;
    int unsigned pick;
    pick = $urandom_range(99);
    pos  = {cur_ab[1], ^cur_ab};
    if (pick < 60) begin
      pos = pos + ($urandom_range(1) ? 2'd1 : 2'd3);
      return {pos[1], ^pos};
    end else if (pick < 85) begin
      return cur_ab;
    end
    return 2'($urandom_range(3));
  endfunction

  task automatic smp(input logic [1:0] ab, input logic btn, input int unsigned adv);
    clock_ms = clock_ms + adv;
    cur_ab   = ab;
    send_item(ab, btn, clock_ms);
  endtask

  task automatic rnd_smp(input logic btn, input int unsigned adv);
    smp(next_ab(), btn, adv);
  endtask

  // one button gesture scaled to the current hold time and timeout
  task automatic gesture();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // click series, closed by a gap near the timeout
      n = $urandom_range(1, 4);
      repeat (n) begin
        rnd_smp(1'b1, $urandom_range(0, timeout_cfg));
        if ($urandom_range(3) == 0)
          rnd_smp(1'b1, $urandom_range(0, hold_cfg) / 2);
        rnd_smp(1'b0, $urandom_range(0, hold_cfg) / 2);
      end
      rnd_smp(1'b0, timeout_cfg + $urandom_range(0, 3));
    end else if (pick < 70) begin
      // long press that may or may not reach the hold time
      rnd_smp(1'b1, $urandom_range(0, timeout_cfg));
      repeat ($urandom_range(2, 5))
        rnd_smp(1'b1, hold_cfg / 3 + $urandom_range(0, 2));
      rnd_smp(1'b0, $urandom_range(0, 5));
    end else if (pick < 95) begin
      // noise on the button pin
      repeat ($urandom_range(1, 6))
        rnd_smp(1'($urandom_range(1)), $urandom_range(0, 2 * (hold_cfg + timeout_cfg) + 4));
    end else begin
      // arbitrary jump of the timestamp, wraps included
      rnd_smp(1'($urandom_range(1)), $urandom);
    end
    // now and then let the pipeline run dry before going on
    if ($urandom_range(49) == 0)
      wait_drained();
  endtask

  initial begin
    sb                = new();
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_enc_ab         = '0;
    in_button_pressed = 1'b0;
    in_now_ms         = '0;
    out_ready         = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    clock_ms          = '0;
    cur_ab            = '0;
    hold_cfg          = HOLD_TIME_RST;
    timeout_cfg       = CLICK_TIMEOUT_RST;
    sent              = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset register values (hold 500, timeout 300)
    clock_ms = 32'hFFFF_FF00;
    smp(2'd3, 1'b1, 0);     // first sample only primes the phase history
    smp(2'd1, 1'b1, 16);    // press, reverse step
    smp(2'd0, 1'b0, 256);   // short press across the timestamp wrap
    smp(2'd2, 1'b0, 301);   // gap past the timeout reports one click
    smp(2'd0, 1'b0, 1);     // forward steps round the whole cycle
    smp(2'd1, 1'b1, 5);
    smp(2'd3, 1'b0, 50);
    smp(2'd2, 1'b1, 100);
    smp(2'd0, 1'b0, 100);   // second click inside the timeout
    smp(2'd3, 1'b1, 100);   // both phases change: no step
    smp(2'd3, 1'b1, 499);   // one ms short of the hold time
    smp(2'd3, 1'b1, 1);     // hold reached with clicks pending: hold wins
    smp(2'd3, 1'b1, 1000);  // hold reported only once
    smp(2'd1, 1'b0, 1);     // release after a hold is no click
    smp(2'd2, 1'b0, 1);
    smp(2'd2, 1'b1, 1);
    smp(2'd2, 1'b0, 10);
    smp(2'd2, 1'b1, 10);
    smp(2'd2, 1'b0, 10);
    smp(2'd2, 1'b0, 300);   // gap equal to the timeout keeps the series open
    smp(2'd2, 1'b0, 1);
    clock_ms = '1;
    smp(2'd0, 1'b1, 0);     // press at the top of the timestamp range
    clock_ms = '0;
    smp(2'd1, 1'b0, 0);     // release at zero
    smp(2'd1, 1'b0, 301);

    // zero hold time and timeout: every press is a hold at once
    wait_drained();
    set_regs(0, 0, 16'h0001);
    while (sent < 260)
      gesture();

    // widest settings, with a click burst long enough to saturate the count
    wait_drained();
    set_regs(16'hFFFF, 16'hFFFF, 16'h0001);
    repeat (262) begin
      rnd_smp(1'b1, $urandom_range(1, 20));
      rnd_smp(1'b0, $urandom_range(1, 20));
    end
    rnd_smp(1'b0, 32'h0001_0000 + $urandom_range(0, 99));
    while (sent < 950)
      gesture();

    // button disabled, the enable word only keeps its low bit
    wait_drained();
    set_regs($urandom_range(0, 400), $urandom_range(0, 300), 16'hFFFE);
    while (sent < 1100)
      gesture();

    // enabled again with short times, first stretch without any idling
    wait_drained();
    set_regs($urandom_range(1, 300), $urandom_range(1, 200), 16'hFFFF);
    steady = 1'b1;
    while (sent < 1250)
      gesture();
    steady = 1'b0;
    while (sent < 1350)
      gesture();

    // arbitrary full-range settings
    wait_drained();
    set_regs($urandom_range(0, 65535), $urandom_range(0, 65535), 16'h0001);
    while (sent < 1450)
      gesture();

    // back to the reset values
    wait_drained();
    set_regs(HOLD_TIME_RST, CLICK_TIMEOUT_RST, {15'd0, BUTTON_EN_RST});
    while (sent < 1575)
      gesture();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
